FILE: hw/rtl/ppn_pkg.sv
// ----------------------------------------------------------------------------
// ppn_pkg
// Shared widths, datapath operation codes and controller/datapath
// interface types for the point to polyline nearest-point block.
// ----------------------------------------------------------------------------
package ppn_pkg;

  localparam int COORD_W      = 24;
  localparam int FRAC_W       = 16;
  localparam int PARAM_W      = FRAC_W + 1;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int DOT_W        = PROD_W + 2;
  localparam int DIST_W       = 50;
  localparam int REM_W        = DIST_W + 1;
  localparam int SPAN_W       = 16;
  localparam int STATUS_W     = 2;
  localparam int MAX_VERTICES = 65536;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 2);
  localparam int STEP_W       = 5;
  localparam int DIV_STEPS    = PARAM_W;

  // shared multiplier operand selection
  localparam logic [3:0] MUL_DXPX = 4'd0;
  localparam logic [3:0] MUL_DYPY = 4'd1;
  localparam logic [3:0] MUL_DZPZ = 4'd2;
  localparam logic [3:0] MUL_DXDX = 4'd3;
  localparam logic [3:0] MUL_DYDY = 4'd4;
  localparam logic [3:0] MUL_DZDZ = 4'd5;
  localparam logic [3:0] MUL_PDX  = 4'd6;
  localparam logic [3:0] MUL_PDY  = 4'd7;
  localparam logic [3:0] MUL_PDZ  = 4'd8;
  localparam logic [3:0] MUL_EXEX = 4'd9;
  localparam logic [3:0] MUL_EYEY = 4'd10;
  localparam logic [3:0] MUL_EZEZ = 4'd11;

  // accumulator target for the registered product
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_DOT  = 2'd1;
  localparam logic [1:0] ACC_LEN  = 2'd2;
  localparam logic [1:0] ACC_DIST = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       load_query;
    logic       overflow;
    logic       acc_clr;
    logic [3:0] mul_sel;
    logic [1:0] acc_sel;
    logic       sel_end;
    logic       sel_start;
    logic       div_init;
    logic       div_step;
    logic       param_fix;
    logic       near_wr;
    logic [1:0] near_idx;
    logic       update;
    logic       store;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic opcode;
    logic last;
    logic count_zero;
    logic count_full;
    logic seg_end;
    logic seg_start;
  } dp_stat_t;

endpackage

FILE: hw/rtl/ppn_ctrl.sv
// ----------------------------------------------------------------------------
// ppn_ctrl
// Sequencer for one transaction: dispatch, query load, dot/length products,
// clamp decision, restoring division, nearest point, distance, best update and store.
// ----------------------------------------------------------------------------
module ppn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ppn_pkg::dp_stat_t stat,
  output ppn_pkg::dp_cmd_t  cmd
);
  import ppn_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_DIFF   = 4'd2;
  localparam logic [3:0] S_MAC    = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_PFIX   = 4'd6;
  localparam logic [3:0] S_NEAR   = 4'd7;
  localparam logic [3:0] S_DIST   = 4'd8;
  localparam logic [3:0] S_UPD    = 4'd9;
  localparam logic [3:0] S_STORE  = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;

  assign busy = (state != S_IDLE);

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    step_next  = '0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        if (!stat.opcode) begin
          cmd.load_query = 1'b1;
          state_next     = S_IDLE;
        end else if (stat.count_full) begin
          cmd.overflow = 1'b1;
          state_next   = S_FIN;
        end else if (stat.count_zero) begin
          state_next = S_STORE;
        end else begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.acc_clr = 1'b1;
        state_next  = S_MAC;
      end
      S_MAC: begin
        case (step)
          5'd0: cmd.mul_sel = MUL_DXPX;
          5'd1: cmd.mul_sel = MUL_DYPY;
          5'd2: cmd.mul_sel = MUL_DZPZ;
          5'd3: cmd.mul_sel = MUL_DXDX;
          5'd4: cmd.mul_sel = MUL_DYDY;
          5'd5: cmd.mul_sel = MUL_DZDZ;
          default: cmd.mul_sel = MUL_DXPX;
        endcase
        if (step >= 5'd1 && step <= 5'd3) cmd.acc_sel = ACC_DOT;
        else if (step >= 5'd4) cmd.acc_sel = ACC_LEN;
        if (step == 5'd6) begin
          state_next = S_DECIDE;
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_DECIDE: begin
        if (stat.seg_end) begin
          cmd.sel_end = 1'b1;
          state_next  = S_DIST;
        end else if (stat.seg_start) begin
          cmd.sel_start = 1'b1;
          state_next    = S_DIST;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_PFIX;
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_PFIX: begin
        cmd.param_fix = 1'b1;
        state_next    = S_NEAR;
      end
      S_NEAR: begin
        case (step)
          5'd0: cmd.mul_sel = MUL_PDX;
          5'd1: cmd.mul_sel = MUL_PDY;
          5'd2: cmd.mul_sel = MUL_PDZ;
          default: cmd.mul_sel = MUL_PDX;
        endcase
        if (step != 5'd0) begin
          cmd.near_wr  = 1'b1;
          cmd.near_idx = step[1:0] - 2'd1;
        end
        if (step == 5'd3) begin
          state_next = S_DIST;
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_DIST: begin
        case (step)
          5'd0: cmd.mul_sel = MUL_EXEX;
          5'd1: cmd.mul_sel = MUL_EYEY;
          5'd2: cmd.mul_sel = MUL_EZEZ;
          default: cmd.mul_sel = MUL_EXEX;
        endcase
        if (step != 5'd0) cmd.acc_sel = ACC_DIST;
        if (step == 5'd3) begin
          state_next = S_UPD;
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_STORE;
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.emit   = stat.last;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/ppn_dp.sv
// ----------------------------------------------------------------------------
// ppn_dp
// Datapath: input and vertex registers, shared 25x25 multiplier with
// accumulators, restoring divider, nearest-point rounding, best tracking
// and the registered result.
// ----------------------------------------------------------------------------
module ppn_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   three_d,
  input  logic                                   opcode,
  input  logic signed [ppn_pkg::COORD_W-1:0]     coord_x,
  input  logic signed [ppn_pkg::COORD_W-1:0]     coord_y,
  input  logic signed [ppn_pkg::COORD_W-1:0]     coord_z,
  input  logic                                   last_vertex,
  input  ppn_pkg::dp_cmd_t                       cmd,
  output ppn_pkg::dp_stat_t                      stat,
  output logic                                   done,
  output logic [ppn_pkg::DIST_W-1:0]             min_dist_sq,
  output logic [ppn_pkg::SPAN_W-1:0]             span_index,
  output logic [ppn_pkg::PARAM_W-1:0]            span_param,
  output logic signed [ppn_pkg::COORD_W-1:0]     near_x,
  output logic signed [ppn_pkg::COORD_W-1:0]     near_y,
  output logic signed [ppn_pkg::COORD_W-1:0]     near_z,
  output logic [ppn_pkg::STATUS_W-1:0]           status
);
  import ppn_pkg::*;

  logic                      in_op, in_last;
  logic signed [COORD_W-1:0] cur [3];
  logic signed [COORD_W-1:0] query [3];
  logic signed [COORD_W-1:0] prev [3];
  logic [CNT_W-1:0]          count;
  logic signed [DIFF_W-1:0]  dv [3];
  logic signed [DIFF_W-1:0]  pv [3];
  logic signed [DIFF_W-1:0]  ev [3];
  logic signed [COORD_W-1:0] qv [3];
  logic signed [COORD_W-1:0] av [3];
  logic signed [COORD_W-1:0] bv [3];
  logic signed [COORD_W-1:0] nr [3];
  logic signed [PROD_W-1:0]  prod;
  logic signed [DIFF_W-1:0]  ma, mb;
  logic signed [DOT_W-1:0]   dot;
  logic [DIST_W-1:0]         len;
  logic [DIST_W-1:0]         dist_acc;
  logic [REM_W-1:0]          rem, rem2;
  logic [PARAM_W-1:0]        quo;
  logic [PARAM_W-1:0]        param;
  logic signed [PROD_W-1:0]  rnd, shf;
  logic [DIST_W-1:0]         best_dist;
  logic [SPAN_W-1:0]         best_span;
  logic [PARAM_W-1:0]        best_param;
  logic signed [COORD_W-1:0] best_pt [3];
  logic [STATUS_W-1:0]       st_code;

  // z is treated as zero in 2D mode
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv[i] = (i == 2 && !three_d) ? '0 : query[i];
      av[i] = (i == 2 && !three_d) ? '0 : prev[i];
      bv[i] = (i == 2 && !three_d) ? '0 : cur[i];
      ev[i] = {qv[i][COORD_W-1], qv[i]} - {nr[i][COORD_W-1], nr[i]};
    end
  end

  // status toward the controller
  assign stat.opcode     = in_op;
  assign stat.last       = in_last;
  assign stat.count_zero = (count == '0);
  assign stat.count_full = (count >= CNT_W'(MAX_VERTICES));
  assign stat.seg_end    = (len == '0) ||
                           (dot > 0 && dot >= $signed({2'b00, len}));
  assign stat.seg_start  = (dot <= 0);

  // shared multiplier operand selection
  always_comb begin
    case (cmd.mul_sel)
      MUL_DXPX: begin ma = dv[0]; mb = pv[0]; end
      MUL_DYPY: begin ma = dv[1]; mb = pv[1]; end
      MUL_DZPZ: begin ma = dv[2]; mb = pv[2]; end
      MUL_DXDX: begin ma = dv[0]; mb = dv[0]; end
      MUL_DYDY: begin ma = dv[1]; mb = dv[1]; end
      MUL_DZDZ: begin ma = dv[2]; mb = dv[2]; end
      MUL_PDX:  begin ma = $signed({(DIFF_W-PARAM_W)'(0), param}); mb = dv[0]; end
      MUL_PDY:  begin ma = $signed({(DIFF_W-PARAM_W)'(0), param}); mb = dv[1]; end
      MUL_PDZ:  begin ma = $signed({(DIFF_W-PARAM_W)'(0), param}); mb = dv[2]; end
      MUL_EXEX: begin ma = ev[0]; mb = ev[0]; end
      MUL_EYEY: begin ma = ev[1]; mb = ev[1]; end
      MUL_EZEZ: begin ma = ev[2]; mb = ev[2]; end
      default:  begin ma = dv[0]; mb = pv[0]; end
    endcase
  end

  // rounding of param*d, halves toward plus infinity
  assign rnd  = prod + PROD_W'(1 << (FRAC_W - 1));
  assign shf  = rnd >>> FRAC_W;
  assign rem2 = {rem[REM_W-2:0], 1'b0};

  // status of the finished polyline
  always_comb begin
    if (count > CNT_W'(MAX_VERTICES)) st_code = ST_OVERFLOW;
    else if (count < CNT_W'(2))       st_code = ST_SHORT;
    else                              st_code = ST_OK;
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (cmd.capture) begin
      in_op   <= opcode;
      in_last <= last_vertex;
      cur[0]  <= coord_x;
      cur[1]  <= coord_y;
      cur[2]  <= coord_z;
    end
    if (cmd.acc_clr) begin
      for (int i = 0; i < 3; i++) begin
        dv[i] <= {bv[i][COORD_W-1], bv[i]} - {av[i][COORD_W-1], av[i]};
        pv[i] <= {qv[i][COORD_W-1], qv[i]} - {av[i][COORD_W-1], av[i]};
      end
      dot      <= '0;
      len      <= '0;
      dist_acc <= '0;
    end else begin
      case (cmd.acc_sel)
        ACC_DOT:  dot      <= dot + DOT_W'(prod);
        ACC_LEN:  len      <= len + prod[DIST_W-1:0];
        ACC_DIST: dist_acc <= dist_acc + prod[DIST_W-1:0];
        default:  ;
      endcase
    end
    if (cmd.div_init) begin
      rem <= {1'b0, dot[DIST_W-1:0]};
      quo <= '0;
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, len}) begin
        rem <= rem2 - {1'b0, len};
        quo <= {quo[PARAM_W-2:0], 1'b1};
      end else begin
        rem <= rem2;
        quo <= {quo[PARAM_W-2:0], 1'b0};
      end
    end
    if (cmd.sel_end) begin
      param <= PARAM_W'(1 << FRAC_W);
      for (int i = 0; i < 3; i++) nr[i] <= bv[i];
    end else if (cmd.sel_start) begin
      param <= '0;
      for (int i = 0; i < 3; i++) nr[i] <= av[i];
    end else if (cmd.param_fix) begin
      param <= PARAM_W'(({1'b0, quo} + 1'b1) >> 1);
    end
    if (cmd.near_wr) begin
      nr[cmd.near_idx] <= av[cmd.near_idx] + shf[COORD_W-1:0];
    end
  end

  // polyline and best-segment state
  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      count      <= '0;
      best_dist  <= '1;
      best_span  <= '0;
      best_param <= '0;
      for (int i = 0; i < 3; i++) begin
        query[i]   <= '0;
        prev[i]    <= '0;
        best_pt[i] <= '0;
      end
    end else begin
      done <= cmd.emit;
      if (cmd.load_query || cmd.emit) begin
        count      <= '0;
        best_dist  <= '1;
        best_span  <= '0;
        best_param <= '0;
        for (int i = 0; i < 3; i++) begin
          prev[i]    <= '0;
          best_pt[i] <= '0;
        end
      end
      if (cmd.load_query) begin
        for (int i = 0; i < 3; i++) query[i] <= cur[i];
      end
      if (cmd.overflow) count <= CNT_W'(MAX_VERTICES + 1);
      if (cmd.store) begin
        count <= count + 1'b1;
        for (int i = 0; i < 3; i++) prev[i] <= cur[i];
      end
      if (cmd.update && dist_acc < best_dist) begin
        best_dist  <= dist_acc;
        best_span  <= SPAN_W'(count - 1'b1);
        best_param <= param;
        for (int i = 0; i < 3; i++) best_pt[i] <= nr[i];
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status <= st_code;
      if (st_code == ST_OK) begin
        min_dist_sq <= best_dist;
        span_index  <= best_span;
        span_param  <= best_param;
        near_x      <= best_pt[0];
        near_y      <= best_pt[1];
        near_z      <= three_d ? best_pt[2] : '0;
      end else begin
        min_dist_sq <= '0;
        span_index  <= '0;
        span_param  <= '0;
        near_x      <= '0;
        near_y      <= '0;
        near_z      <= '0;
      end
    end
  end

endmodule

FILE: hw/rtl/point_polyline_nearest_top.sv
// ----------------------------------------------------------------------------
// point_polyline_nearest_top
// Nearest point on a 2D/3D polyline to a query point.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken when start is high and busy is low. opcode 0
// loads the query point and starts a new polyline (no result).
// opcode 1 delivers one vertex; with last_vertex set, the answer appears on
// the result ports, marked by done high for exactly one cycle, once the vertex
// is finished. The receiver cannot stall the block.
// An overflowed vertex goes straight to the finish, a first vertex is only
// stored, a vertex closing a segment clamped to an end skips the divider and
// an interior projection runs the 17-step restoring divider. The single shared
// 25x25 multiplier is used for dot, length, nearest point and distance.
// Reset: three_d is 1, query point the origin, polyline and best cleared. The user
// writes register three_d (byte address 0) over the APB port only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module point_polyline_nearest_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               start,
  output logic                               busy,
  input  logic                               opcode,
  input  logic signed [ppn_pkg::COORD_W-1:0] coord_x,
  input  logic signed [ppn_pkg::COORD_W-1:0] coord_y,
  input  logic signed [ppn_pkg::COORD_W-1:0] coord_z,
  input  logic                               last_vertex,
  output logic                               done,
  output logic [ppn_pkg::DIST_W-1:0]         min_dist_sq,
  output logic [ppn_pkg::SPAN_W-1:0]         span_index,
  output logic [ppn_pkg::PARAM_W-1:0]        span_param,
  output logic signed [ppn_pkg::COORD_W-1:0] near_x,
  output logic signed [ppn_pkg::COORD_W-1:0] near_y,
  output logic signed [ppn_pkg::COORD_W-1:0] near_z,
  output logic [ppn_pkg::STATUS_W-1:0]       status
);
  import ppn_pkg::*;

  logic     three_d;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, three_d} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      three_d <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      three_d <= pwdata[0];
    end
  end

  ppn_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ppn_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .three_d     (three_d),
    .opcode      (opcode),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .last_vertex (last_vertex),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .min_dist_sq (min_dist_sq),
    .span_index  (span_index),
    .span_param  (span_param),
    .near_x      (near_x),
    .near_y      (near_y),
    .near_z      (near_z),
    .status      (status)
  );

endmodule
